// File: rtl/efp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned NzW      = 34;
  localparam int unsigned CountW   = 16;
  localparam int unsigned GrayW    = 8;
  localparam int unsigned ColorW   = 3 * GrayW;
  localparam int unsigned DivW     = CountW + GrayW;
  localparam int unsigned DivStepW = $clog2(GrayW + 1);
  localparam int unsigned OutDataW = ((CountW + ColorW + 7) / 8) * 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgRealOrigin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImagOrigin = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRealStep   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImagStep   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxIter    = 3'd4;

  localparam logic signed [CoordW-1:0] RealOriginRst = 32'shE000_0000;
  localparam logic signed [CoordW-1:0] ImagOriginRst = 32'shF000_0000;
  localparam logic signed [CoordW-1:0] RealStepRst   = 32'sh0004_0000;
  localparam logic signed [CoordW-1:0] ImagStepRst   = 32'sh0004_0000;
  localparam logic [CountW-1:0]        MaxIterRst    = 16'd256;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

endpackage

`default_nettype wire

// File: rtl/efp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module efp_mul
  import efp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [CoordW-1:0] a_i,
  input  wire logic signed [CoordW-1:0] b_i,
  output logic signed [ProdW-1:0]       p_o
);

  logic signed [ProdW-1:0] p_d;
  logic signed [ProdW-1:0] p_q;

  assign p_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/efp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module efp_div
  import efp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DivW-1:0]   dividend_i,
  input  wire logic [CountW-1:0] divisor_i,
  output logic                   done_o,
  output logic [GrayW-1:0]       quotient_o
);

  logic                busy_q;
  logic                done_q;
  logic [DivStepW-1:0] cnt_q;
  logic [CountW-1:0]   rem_q;
  logic [CountW-1:0]   rem_d;
  logic [GrayW-1:0]    dsh_q;
  logic [GrayW-1:0]    quo_q;
  logic [CountW:0]     trial;
  logic [CountW:0]     trial_sub;
  logic                fits;

  // The quotient never exceeds eight bits, so the upper dividend bits start
  // out as a remainder that is already below the divisor.
  assign trial     = {rem_q, dsh_q[GrayW-1]};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign fits      = trial >= {1'b0, divisor_i};
  assign rem_d     = fits ? trial_sub[CountW-1:0] : trial[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivStepW'(GrayW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivStepW'(1);
        if (cnt_q == DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DivW-1:GrayW];
      dsh_q <= dividend_i[GrayW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dsh_q <= {dsh_q[GrayW-2:0], 1'b0};
      quo_q <= {quo_q[GrayW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Escape-time fractal pixel engine.
// A request on the slave stream carries one pixel (column in the low bits,
// row above it). The block forms c = origin + index * step per axis in signed
// fixed point, iterates z := z*z - c from zero and reports the first step at
// which |z| reaches 2, or 0 if the iteration limit runs out. A gray level
// floor(255 * n / limit) is repeated in the three color bytes.
// All products go through one registered 32 x 32 multiplier. A pixel passes
// through setting up c, iterations of three products each, the gray divide
// and the load of the output register. The slave tready is high only while
// the engine is idle. The user must write registers through the cfg port only
// while the engine is idle; the block itself does not enforce this.
// The finished result sits in an output register until the master side takes
// it; a new pixel may be accepted meanwhile, and its result waits in the
// engine while the receiver stalls. Reset empties the output register, returns
// the engine to idle and loads the default view and a limit of 256.
module escape_time_fractal_pixel
  import efp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = 12,
  parameter int unsigned ROW_BITS    = 12,
  parameter int unsigned FRAC_BITS   = 28,
  localparam int unsigned InDataW    = ((COLUMN_BITS + ROW_BITS + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // column, row
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // iteration_count, pixel_color
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCr     = 4'd1;
  localparam logic [3:0] StCi     = 4'd2;
  localparam logic [3:0] StCsat   = 4'd3;
  localparam logic [3:0] StCross  = 4'd4;
  localparam logic [3:0] StNewZ   = 4'd5;
  localparam logic [3:0] StRange  = 4'd6;
  localparam logic [3:0] StSqr    = 4'd7;
  localparam logic [3:0] StSum    = 4'd8;
  localparam logic [3:0] StGstart = 4'd9;
  localparam logic [3:0] StGwait  = 4'd10;
  localparam logic [3:0] StOut    = 4'd11;

  localparam logic signed [NzW-1:0] Two    = $signed(NzW'(1) << (FRAC_BITS + 1));
  localparam logic signed [NzW-1:0] NegTwo = -Two;
  localparam logic signed [ProdW-1:0] FourSq = $signed(ProdW'(1) << (2 * FRAC_BITS + 2));

  logic [3:0] state_q;

  logic signed [CoordW-1:0] real_origin_q;
  logic signed [CoordW-1:0] imag_origin_q;
  logic signed [CoordW-1:0] real_step_q;
  logic signed [CoordW-1:0] imag_step_q;
  logic [CountW-1:0]        max_iter_q;

  logic [COLUMN_BITS-1:0]   col_q;
  logic [ROW_BITS-1:0]      row_q;
  logic signed [CoordW-1:0] cr_q;
  logic signed [CoordW-1:0] ci_q;
  logic signed [CoordW-1:0] zr_q;
  logic signed [CoordW-1:0] zi_q;
  logic signed [ProdW-1:0]  diff_q;
  logic signed [ProdW-1:0]  sqr_q;
  logic signed [ProdW-1:0]  sqi_q;
  logic signed [NzW-1:0]    nr_q;
  logic signed [NzW-1:0]    ni_q;
  logic [CountW-1:0]        n_q;
  logic [CountW-1:0]        count_q;
  logic [GrayW-1:0]         gray_q;

  logic                     m_valid_q;
  logic [OutDataW-1:0]      m_data_q;

  logic signed [CoordW-1:0] mul_a;
  logic signed [CoordW-1:0] mul_b;
  logic signed [ProdW-1:0]  p;

  logic signed [CoordW-1:0] origin_sel;
  logic signed [ProdW-1:0]  csum;
  logic signed [CoordW-1:0] csat;
  logic signed [ProdW-1:0]  diff_sh;
  logic signed [ProdW-1:0]  cross_sh;
  logic signed [NzW-1:0]    nr_d;
  logic signed [NzW-1:0]    ni_d;
  logic                     out_range;
  logic signed [ProdW-1:0]  sq_sum;
  logic                     escaped;

  logic                     s_accept;
  logic                     out_load;
  logic                     div_start;
  logic                     div_done;
  logic [GrayW-1:0]         quotient;
  logic [DivW-1:0]          dividend;

  assign s_accept  = s_axis_tvalid_i && (state_q == StIdle);
  assign out_load  = (state_q == StOut) && (!m_valid_q || m_axis_tready_i);
  assign div_start = (state_q == StGstart);
  assign dividend  = {count_q, GrayW'(0)} - DivW'(count_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StCr: begin
        mul_a = $signed(CoordW'(col_q));
        mul_b = real_step_q;
      end
      StCi: begin
        mul_a = $signed(CoordW'(row_q));
        mul_b = imag_step_q;
      end
      StCross: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      StRange: begin
        mul_a = nr_q[CoordW-1:0];
        mul_b = nr_q[CoordW-1:0];
      end
      StSqr: begin
        mul_a = ni_q[CoordW-1:0];
        mul_b = ni_q[CoordW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  efp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  efp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (max_iter_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign origin_sel = (state_q == StCi) ? real_origin_q : imag_origin_q;
  assign csum       = p + ProdW'(origin_sel);

  always_comb begin
    if (csum > ProdW'(CoordMax)) begin
      csat = CoordMax;
    end else if (csum < ProdW'(CoordMin)) begin
      csat = CoordMin;
    end else begin
      csat = csum[CoordW-1:0];
    end
  end

  assign diff_sh  = diff_q >>> FRAC_BITS;
  assign cross_sh = (p <<< 1) >>> FRAC_BITS;
  assign nr_d     = $signed(diff_sh[NzW-1:0]) - NzW'(cr_q);
  assign ni_d     = $signed(cross_sh[NzW-1:0]) - NzW'(ci_q);

  assign out_range = (nr_q >= Two) || (nr_q <= NegTwo) || (ni_q >= Two) || (ni_q <= NegTwo);
  assign sq_sum    = sqr_q + p;
  assign escaped   = sq_sum >= FourSq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= RealOriginRst;
      imag_origin_q <= ImagOriginRst;
      real_step_q   <= RealStepRst;
      imag_step_q   <= ImagStepRst;
      max_iter_q    <= MaxIterRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRealOrigin: real_origin_q <= $signed(cfg_wdata_i);
        CfgImagOrigin: imag_origin_q <= $signed(cfg_wdata_i);
        CfgRealStep:   real_step_q   <= $signed(cfg_wdata_i);
        CfgImagStep:   imag_step_q   <= $signed(cfg_wdata_i);
        CfgMaxIter:    max_iter_q    <= cfg_wdata_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_accept) begin
            state_q <= StCr;
          end
        end
        StCr:    state_q <= StCi;
        StCi:    state_q <= StCsat;
        StCsat:  state_q <= (max_iter_q == '0) ? StGstart : StCross;
        StCross: state_q <= StNewZ;
        StNewZ:  state_q <= StRange;
        StRange: state_q <= out_range ? StGstart : StSqr;
        StSqr:   state_q <= StSum;
        StSum: begin
          if (escaped || (n_q == max_iter_q)) begin
            state_q <= StGstart;
          end else begin
            state_q <= StCross;
          end
        end
        StGstart: state_q <= StGwait;
        StGwait: begin
          if (div_done) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (s_accept) begin
          col_q <= s_axis_tdata_i[COLUMN_BITS-1:0];
          row_q <= s_axis_tdata_i[COLUMN_BITS+ROW_BITS-1:COLUMN_BITS];
        end
      end
      StCi: cr_q <= csat;
      StCsat: begin
        ci_q    <= csat;
        zr_q    <= '0;
        zi_q    <= '0;
        sqr_q   <= '0;
        sqi_q   <= '0;
        n_q     <= '0;
        count_q <= '0;
      end
      StCross: begin
        diff_q <= sqr_q - sqi_q;
        n_q    <= n_q + CountW'(1);
      end
      StNewZ: begin
        nr_q <= nr_d;
        ni_q <= ni_d;
      end
      StRange: begin
        if (out_range) begin
          count_q <= n_q;
        end
      end
      StSqr: sqr_q <= p;
      StSum: begin
        sqi_q <= p;
        zr_q  <= nr_q[CoordW-1:0];
        zi_q  <= ni_q[CoordW-1:0];
        if (escaped) begin
          count_q <= n_q;
        end else begin
          count_q <= '0;
        end
      end
      StGwait: begin
        if (div_done) begin
          gray_q <= (max_iter_q == '0) ? GrayW'(0) : quotient;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_data_q <= OutDataW'({gray_q, gray_q, gray_q, count_q});
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

// File: sim/tb_escape_time_fractal_pixel.sv
`timescale 1ns / 1ps

module tb_escape_time_fractal_pixel;
  import efp_pkg::*;

  localparam int unsigned ColBits  = 12;
  localparam int unsigned RowBits  = 12;
  localparam int unsigned FracBits = 28;
  localparam int unsigned InDataW  = ((ColBits + RowBits + 7) / 8) * 8;
  localparam int unsigned GrayMax  = 255;
  localparam int unsigned HalfCols = 1 << (ColBits - 1);
  localparam int unsigned HalfRows = 1 << (RowBits - 1);
  localparam int unsigned CycleLimit  = 4_000_000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned HoldCycles  = 3000;
  localparam longint      TwoQ   = longint'(2) << FracBits;
  localparam longint      FourSq = longint'(4) << (2 * FracBits);

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [CountW-1:0] count;
  } pixel_result_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tready  = 1'b0;
  wire logic                s_tready;
  wire logic                m_tvalid;
  wire logic [OutDataW-1:0] m_tdata;

  longint      view_re_origin = longint'(RealOriginRst);
  longint      view_im_origin = longint'(ImagOriginRst);
  longint      view_re_step   = longint'(RealStepRst);
  longint      view_im_step   = longint'(ImagStepRst);
  int unsigned iter_limit     = 32'(MaxIterRst);

  pixel_result_t       pending_pixels[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         hold_left      = 0;
  logic                out_valid_seen = 1'b0;
  logic [OutDataW-1:0] out_data_seen  = '0;

  escape_time_fractal_pixel #(
    .COLUMN_BITS(ColBits),
    .ROW_BITS   (RowBits),
    .FRAC_BITS  (FracBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint clamp_coord(input longint value);
    if (value > longint'(CoordMax)) return longint'(CoordMax);
    if (value < longint'(CoordMin)) return longint'(CoordMin);
    return value;
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [ColBits-1:0] col,
                                                 input logic [RowBits-1:0] row);
    longint        cr, ci, zr, zi, nr, ni;
    int unsigned   steps;
    int unsigned   escaped_at;
    int unsigned   gray;
    pixel_result_t res;
    cr = clamp_coord(view_re_origin + longint'(col) * view_re_step);
    ci = clamp_coord(view_im_origin + longint'(row) * view_im_step);
    zr = 0;
    zi = 0;
    steps = 0;
    escaped_at = 0;
    while (escaped_at == 0 && steps < iter_limit) begin
      steps++;
      nr = ((zr * zr - zi * zi) >>> FracBits) - cr;
      ni = ((2 * zr * zi) >>> FracBits) - ci;
      if (nr >= TwoQ || nr <= -TwoQ || ni >= TwoQ || ni <= -TwoQ ||
          nr * nr + ni * ni >= FourSq) begin
        escaped_at = steps;
      end
      zr = nr;
      zi = ni;
    end
    gray = (iter_limit == 0) ? 0 : (GrayMax * escaped_at) / iter_limit;
    res.count = escaped_at[CountW-1:0];
    res.color = {3{gray[GrayW-1:0]}};
    return res;
  endfunction

  function automatic void check_pixel(input logic [OutDataW-1:0] data);
    pixel_result_t want;
    pixel_result_t got;
    got = data[CountW+ColorW-1:0];
    if (pending_pixels.size() == 0) begin
      $error("unexpected result: iteration_count %0d, pixel_color %h", got.count, got.color);
      mismatch_count++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.count !== want.count) begin
        $error("iteration_count: expected %0d, actual %0d", want.count, got.count);
        mismatch_count++;
      end
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, actual %h", want.color, got.color);
        mismatch_count++;
      end
    end
  endfunction

  always @(negedge clk_i) begin
    out_valid_seen <= m_tvalid;
    out_data_seen  <= m_tdata;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tready && out_valid_seen) begin
      check_pixel(out_data_seen);
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CfgRealOrigin: view_re_origin = longint'(signed'(data));
      CfgImagOrigin: view_im_origin = longint'(signed'(data));
      CfgRealStep:   view_re_step   = longint'(signed'(data));
      CfgImagStep:   view_im_step   = longint'(signed'(data));
      CfgMaxIter:    iter_limit     = 32'(data[CountW-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_view(input logic [CfgDataW-1:0] re_origin,
                            input logic [CfgDataW-1:0] im_origin,
                            input logic [CfgDataW-1:0] re_step,
                            input logic [CfgDataW-1:0] im_step,
                            input logic [CfgDataW-1:0] limit);
    write_reg(CfgRealOrigin, re_origin);
    write_reg(CfgImagOrigin, im_origin);
    write_reg(CfgRealStep, re_step);
    write_reg(CfgImagStep, im_step);
    write_reg(CfgMaxIter, limit);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // The view is centered on the region where the escape count varies most.
  task automatic random_view(input int unsigned limit_hi);
    longint center_re, center_im, step_re, step_im;
    center_re = longint'($urandom_range(5 * 2**27, 0)) - 2**27;
    center_im = longint'($urandom_range(5 * 2**27, 0)) - 5 * 2**26;
    step_re   = longint'($urandom_range(2**18, 0));
    step_im   = longint'($urandom_range(2**18, 0));
    if ($urandom_range(1, 0) == 1) step_re = -step_re;
    if ($urandom_range(1, 0) == 1) step_im = -step_im;
    write_view(32'(center_re - HalfCols * step_re), 32'(center_im - HalfRows * step_im),
               32'(step_re), 32'(step_im), {16'($urandom()), 16'($urandom_range(limit_hi, 1))});
  endtask

  task automatic send_pixel(input logic [ColBits-1:0] col, input logic [RowBits-1:0] row);
    logic taken;
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'({row, col});
    do begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end while (!taken);
    pending_pixels = {pending_pixels, escape_pixel(col, row)};
  endtask

  task automatic send_random_pixel();
    send_pixel(ColBits'($urandom_range(2**ColBits - 1, 0)),
               RowBits'($urandom_range(2**RowBits - 1, 0)));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  task automatic test_default_view();
    send_pixel(0, 0);
    send_pixel({ColBits{1'b1}}, {RowBits{1'b1}});
    send_pixel(0, {RowBits{1'b1}});
    send_pixel({ColBits{1'b1}}, 0);
    send_pixel(ColBits'(HalfCols), 256);
    send_pixel(512, 256);
    send_pixel(1200, 900);
    wait_for_results();
  endtask

  task automatic test_iteration_limits();
    write_view(RealOriginRst, ImagOriginRst, RealStepRst, ImagStepRst, '0);
    send_pixel(0, 0);
    send_pixel(ColBits'(HalfCols), 256);
    send_pixel({ColBits{1'b1}}, {RowBits{1'b1}});
    wait_for_results();
    write_reg(CfgMaxIter, 1);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    send_pixel(0, 0);
    send_pixel(ColBits'(HalfCols), 256);
    send_pixel({ColBits{1'b1}}, 0);
    wait_for_results();
    write_reg(CfgMaxIter, {CountW{1'b1}});
    cfg_we <= 1'b0;
    @(posedge clk_i);
    send_pixel(0, 0);
    send_pixel({ColBits{1'b1}}, {RowBits{1'b1}});
    send_pixel(0, {RowBits{1'b1}});
    wait_for_results();
    write_view('0, '0, '0, '0, 2000);
    send_pixel({ColBits{1'b1}}, {RowBits{1'b1}});
    wait_for_results();
  endtask

  // A step this large makes index 2 overflow, so a wrapped coordinate would
  // land near zero while a saturated one escapes at once.
  task automatic test_saturation();
    write_view('0, '0, CoordMax, CoordMin, 16);
    send_pixel(2, 0);
    send_pixel(0, 2);
    send_pixel(0, 0);
    send_pixel({ColBits{1'b1}}, {RowBits{1'b1}});
    wait_for_results();
  endtask

  task automatic test_unused_registers();
    for (int i = int'(CfgMaxIter) + 1; i < 2**CfgIdxW; i++) begin
      write_reg(CfgIdxW'(i), $urandom());
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    send_pixel(0, 0);
    send_pixel(2, 2);
    wait_for_results();
  endtask

  task automatic test_random_pixels(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned items, input int unsigned limit_hi);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 45 == 0) begin
        wait_for_results();
        random_view(limit_hi);
      end
      send_random_pixel();
    end
    wait_for_results();
  endtask

  task automatic test_random_registers(input int unsigned items);
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 10 == 0) begin
        wait_for_results();
        write_view($urandom(), $urandom(), $urandom(), $urandom(),
                   {16'($urandom()), 16'($urandom_range(32, 1))});
      end
      send_random_pixel();
    end
    wait_for_results();
  endtask

  // The receiver holds off long enough for the block to fill up and stall
  // its input while the sender keeps offering pixels.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_view(16);
    hold_left = HoldCycles;
    for (int unsigned i = 0; i < 10; i++) begin
      send_random_pixel();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_view();
    test_iteration_limits();
    test_saturation();
    test_unused_registers();
    test_random_pixels(0, 0, 180, 48);
    test_random_pixels(82, 0, 180, 48);
    test_random_pixels(0, 82, 180, 48);
    test_random_pixels(17, 17, 180, 256);
    test_random_registers(40);
    test_backpressure();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
